// ===== sv/ssp_pkg.sv =====
// Shared types, widths, register indexes and saturation helpers for the
// sprite screen projection block. No dependencies.
package ssp_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H     = 3'd7;

  // Transform divider: |numerator| * 2^22 over |determinant|.
  localparam int TN_W = 55;
  localparam int TD_W = 32;
  localparam int TQ_W = 32;
  // Projection dividers: all divide by |depth| (or |depth| times a divisor).
  localparam int BQ_W   = 16;
  localparam int COLN_W = 45;
  localparam int SCLN_W = 29;
  localparam int BD_W   = 37;

  // Front stages, transform divider, four post stages, projection divider,
  // two output stages.
  localparam int PIPE_DEPTH = 3 + (TQ_W + 1) + 4 + (BQ_W + 1) + 2;

  typedef struct packed {
    logic [15:0]        camera_x;
    logic [15:0]        camera_y;
    logic signed [15:0] view_dir_x;
    logic signed [15:0] view_dir_y;
    logic signed [15:0] camera_plane_x;
    logic signed [15:0] camera_plane_y;
    logic [12:0]        screen_width;
    logic [12:0]        screen_height;
  } cam_cfg_t;

  // Operands for the transform dividers, as magnitudes and quotient signs.
  typedef struct packed {
    logic [32:0] nx_mag;
    logic        nx_neg;
    logic [32:0] ny_mag;
    logic        ny_neg;
    logic [31:0] det_mag;
  } front_t;

  function automatic logic signed [31:0] sat_s32(input logic [31:0] q,
                                                 input logic ovf, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      r = (ovf || q > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-q);
    end else begin
      r = (ovf || q > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat_s16(input logic [15:0] q,
                                                 input logic ovf, input logic neg);
    logic signed [15:0] r;
    if (neg) begin
      r = (ovf || q > 16'h8000) ? 16'sh8000 : $signed(-q);
    end else begin
      r = (ovf || q > 16'h7FFF) ? 16'sh7FFF : $signed(q);
    end
    return r;
  endfunction

  function automatic logic [14:0] sat_u15(input logic [15:0] q, input logic ovf);
    logic [14:0] r;
    r = (ovf || q[15]) ? 15'h7FFF : q[14:0];
    return r;
  endfunction

  function automatic logic [14:0] clamp_u15(input logic signed [17:0] x);
    logic [14:0] r;
    if (x < 18'sd0) begin
      r = '0;
    end else if (x > 18'sd32767) begin
      r = 15'h7FFF;
    end else begin
      r = x[14:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_s16(input logic signed [17:0] x);
    logic signed [15:0] r;
    if (x < -18'sd32768) begin
      r = 16'sh8000;
    end else if (x > 18'sd32767) begin
      r = 16'sh7FFF;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/ssp_delay.sv =====
// Enable-gated delay line that carries side data next to the dividers.
// No dependencies.
module ssp_delay #(
  parameter int W = 32,
  parameter int D = 19
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sr [D];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= din;
      for (int k = 1; k < D; k++) begin
        sr[k] <= sr[k-1];
      end
    end
  end

  assign dout = sr[D-1];

endmodule

// ===== sv/ssp_div.sv =====
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Flags overflow when the quotient needs more than QW bits. No dependencies.
module ssp_div #(
  parameter int NW = 55,
  parameter int DW = 32,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n_mag,
  input  logic [DW-1:0] d_mag,
  input  logic          neg_in,
  output logic [QW-1:0] q,
  output logic          ovf,
  output logic          neg
);

  localparam int HW = NW - QW;
  localparam int MW = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem [QW+1];
  logic [DW-1:0] dv  [QW+1];
  logic [QW-1:0] nlo [QW+1];
  logic [QW-1:0] qv  [QW];
  logic [QW:0]   ovf_p;
  logic [QW:0]   neg_p;
  logic [QW:0]   nz_p;
  logic          ovf0;
  logic          nz0;

  // A zero numerator gives zero even over a zero divisor.
  assign nz0  = (n_mag != '0);
  assign ovf0 = (MW'(n_mag[NW-1:QW]) >= MW'(d_mag)) && nz0;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= DW'(n_mag[NW-1:QW]);
      dv[0]  <= d_mag;
      nlo[0] <= n_mag[QW-1:0];
      ovf_p  <= {ovf_p[QW-1:0], ovf0};
      neg_p  <= {neg_p[QW-1:0], neg_in};
      nz_p   <= {nz_p[QW-1:0], nz0};
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_bit
    logic [DW:0] t;
    logic        ge;
    assign t  = {rem[i], nlo[i][QW-1-i]};
    assign ge = (t >= {1'b0, dv[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? DW'(t - {1'b0, dv[i]}) : DW'(t);
        dv[i+1]  <= dv[i];
        nlo[i+1] <= nlo[i];
      end
    end
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          qv[i] <= QW'(ge) << (QW - 1);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          qv[i] <= qv[i-1] | (QW'(ge) << (QW - 1 - i));
        end
      end
    end
  end

  assign q   = nz_p[QW] ? qv[QW-1] : '0;
  assign ovf = ovf_p[QW];
  assign neg = neg_p[QW];

endmodule

// ===== sv/ssp_front.sv =====
// Front stages: sprite offset from the camera, the six products of the
// inverse camera matrix, and the divider operands. Depends on ssp_pkg.
module ssp_front
  import ssp_pkg::*;
(
  input  logic     clk,
  input  logic     en,
  input  logic [15:0] sprite_x,
  input  logic [15:0] sprite_y,
  input  cam_cfg_t cfg,
  output front_t   res
);

  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [32:0] m_diy_dx;
  logic signed [32:0] m_dix_dy;
  logic signed [32:0] m_ply_dx;
  logic signed [32:0] m_plx_dy;
  logic signed [31:0] m_plx_diy;
  logic signed [31:0] m_dix_ply;
  logic signed [33:0] nx;
  logic signed [33:0] ny;
  logic signed [32:0] det;
  logic               det_zero;

  always_comb begin
    nx       = 34'(m_diy_dx) - 34'(m_dix_dy);
    ny       = 34'(m_plx_dy) - 34'(m_ply_dx);
    det      = 33'(m_plx_diy) - 33'(m_dix_ply);
    det_zero = (det == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= $signed({1'b0, sprite_x}) - $signed({1'b0, cfg.camera_x});
      dy <= $signed({1'b0, sprite_y}) - $signed({1'b0, cfg.camera_y});

      m_diy_dx  <= cfg.view_dir_y * dx;
      m_dix_dy  <= cfg.view_dir_x * dy;
      m_ply_dx  <= cfg.camera_plane_y * dx;
      m_plx_dy  <= cfg.camera_plane_x * dy;
      m_plx_diy <= cfg.camera_plane_x * cfg.view_dir_y;
      m_dix_ply <= cfg.view_dir_x * cfg.camera_plane_y;

      // A singular matrix gives zero for both coordinates.
      res.nx_mag  <= det_zero ? '0 : 33'(nx[33] ? -nx : nx);
      res.ny_mag  <= det_zero ? '0 : 33'(ny[33] ? -ny : ny);
      res.nx_neg  <= nx[33] ^ det[32];
      res.ny_neg  <= ny[33] ^ det[32];
      res.det_mag <= 32'(det[32] ? -det : det);
    end
  end

endmodule

// ===== sv/sprite_screen_projection.sv =====
// Top level of the sprite screen projection pipeline.
// Depends on ssp_pkg, ssp_front, ssp_div and ssp_delay.
//
// Usage:
//   Camera position, direction, plane and screen size are written through
//   the cfg channel (cfg_index selects the register, cfg_data carries the
//   value); cfg_ready is always high. Write them only while no sprite is in
//   flight.
//   Each transfer on the s_ channel carries one sprite map position and
//   yields exactly one transfer on the m_ channel with the projected column,
//   drawing rectangle, size, shift, depth and in-front flag.
//   From input transfer to output valid a sprite passes three front
//   stages, a 33-stage divider for the camera transform, four scaling
//   stages, a 17-stage divider for the projection and two output stages.
//   A new sprite is accepted every cycle unless the output stalls.
//   The whole pipeline advances together; when the receiver holds m_tready
//   low with a result waiting, every stage holds and s_tready drops, so
//   nothing is lost or repeated.
//   Reset clears all valid bits and loads the default camera (facing +y,
//   plane 0.66) and a 640 by 480 screen.
module sprite_screen_projection
  import ssp_pkg::*;
#(
  parameter int VERTICAL_SHIFT = 0,
  parameter int HEIGHT_DIVISOR = 1,
  parameter int WIDTH_DIVISOR  = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // sprite_x, sprite_y
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [159:0]         m_tdata,   // screen_column, start_x, end_x, start_y,
                                          // end_y, sprite_height_px, sprite_width_px,
                                          // shift_px, depth, in_front
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int HDIV = (HEIGHT_DIVISOR < 1) ? 1 : HEIGHT_DIVISOR;
  localparam int WDIV = (WIDTH_DIVISOR < 1) ? 1 : WIDTH_DIVISOR;
  localparam logic [SCLN_W-1:0] VSH_MAG =
    SCLN_W'(((VERTICAL_SHIFT < 0) ? -VERTICAL_SHIFT : VERTICAL_SHIFT) * 65536);
  localparam logic VSH_NEG = (VERTICAL_SHIFT < 0);
  localparam int TY_DLY = 3 + (BQ_W + 1);

  cam_cfg_t cfg;
  logic     adv;
  logic [PIPE_DEPTH-1:0] vld;
  front_t   fr;

  // Camera transform results.
  logic [TQ_W-1:0] qx, qy;
  logic ovfx, ovfy, negx, negy;

  logic signed [31:0] p1_tx, p1_ty;
  logic signed [32:0] p2_sum;
  logic [31:0]        p2_tymag;
  logic               p2_tyneg;
  logic signed [45:0] p3_prod;
  logic [BD_W-1:0]    p3_dh, p3_dw;
  logic [31:0]        p3_tymag;
  logic               p3_tyneg;
  logic [COLN_W-1:0]  p4_colmag;
  logic               p4_colneg;
  logic [BD_W-1:0]    p4_dh, p4_dw;
  logic [31:0]        p4_tymag;
  logic               p4_tyneg;

  // Projection results.
  logic [BQ_W-1:0] qc, qs, qh, qw;
  logic ovfc, ovfs, ovfh, ovfw, negc, negs, negh_unused, negw_unused;
  logic [31:0] ty_dly;

  logic signed [15:0] e1_col, e1_shift;
  logic [14:0]        e1_hgt, e1_wid;
  logic signed [31:0] e1_ty;

  logic signed [17:0] sy_sum, ey_sum, sx_sum, ex_sum, hlim, wlim;
  logic signed [17:0] ey_lim, ex_lim;

  logic signed [15:0] screen_column, end_x, end_y, shift_px;
  logic [14:0]        start_x, start_y, sprite_height_px, sprite_width_px;
  logic signed [31:0] depth;
  logic               in_front;

  assign cfg_ready = 1'b1;
  assign adv       = !vld[PIPE_DEPTH-1] || m_tready;
  assign s_tready  = adv;
  assign m_tvalid  = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.camera_x       <= '0;
      cfg.camera_y       <= '0;
      cfg.view_dir_x     <= '0;
      cfg.view_dir_y     <= 16'sd16384;
      cfg.camera_plane_x <= 16'sd10813;
      cfg.camera_plane_y <= '0;
      cfg.screen_width   <= 13'd640;
      cfg.screen_height  <= 13'd480;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CAMERA_X:   cfg.camera_x       <= cfg_data;
        REG_CAMERA_Y:   cfg.camera_y       <= cfg_data;
        REG_VIEW_DIR_X: cfg.view_dir_x     <= $signed(cfg_data);
        REG_VIEW_DIR_Y: cfg.view_dir_y     <= $signed(cfg_data);
        REG_PLANE_X:    cfg.camera_plane_x <= $signed(cfg_data);
        REG_PLANE_Y:    cfg.camera_plane_y <= $signed(cfg_data);
        REG_SCREEN_W:   cfg.screen_width   <= cfg_data[12:0];
        REG_SCREEN_H:   cfg.screen_height  <= cfg_data[12:0];
        default:        cfg.camera_x       <= cfg.camera_x;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_tvalid};
    end
  end

  ssp_front u_front (
    .clk      (clk),
    .en       (adv),
    .sprite_x (s_tdata[15:0]),
    .sprite_y (s_tdata[31:16]),
    .cfg      (cfg),
    .res      (fr)
  );

  ssp_div #(.NW(TN_W), .DW(TD_W), .QW(TQ_W)) u_div_tx (
    .clk (clk), .en (adv),
    .n_mag ({fr.nx_mag, 22'd0}), .d_mag (fr.det_mag), .neg_in (fr.nx_neg),
    .q (qx), .ovf (ovfx), .neg (negx)
  );

  ssp_div #(.NW(TN_W), .DW(TD_W), .QW(TQ_W)) u_div_ty (
    .clk (clk), .en (adv),
    .n_mag ({fr.ny_mag, 22'd0}), .d_mag (fr.det_mag), .neg_in (fr.ny_neg),
    .q (qy), .ovf (ovfy), .neg (negy)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_tx <= sat_s32(qx, ovfx, negx);
      p1_ty <= sat_s32(qy, ovfy, negy);

      p2_sum   <= 33'(p1_tx) + 33'(p1_ty);
      p2_tymag <= p1_ty[31] ? 32'(-p1_ty) : 32'(p1_ty);
      p2_tyneg <= p1_ty[31];

      p3_prod  <= $signed({1'b0, cfg.screen_width[12:1]}) * p2_sum;
      p3_dh    <= BD_W'(p2_tymag) * BD_W'(HDIV);
      p3_dw    <= BD_W'(p2_tymag) * BD_W'(WDIV);
      p3_tymag <= p2_tymag;
      p3_tyneg <= p2_tyneg;

      p4_colmag <= COLN_W'(p3_prod[45] ? -p3_prod : p3_prod);
      p4_colneg <= p3_prod[45] ^ p3_tyneg;
      p4_dh     <= p3_dh;
      p4_dw     <= p3_dw;
      p4_tymag  <= p3_tymag;
      p4_tyneg  <= p3_tyneg;
    end
  end

  ssp_delay #(.W(32), .D(TY_DLY)) u_ty_dly (
    .clk (clk), .en (adv), .din (p1_ty), .dout (ty_dly)
  );

  ssp_div #(.NW(COLN_W), .DW(32), .QW(BQ_W)) u_div_col (
    .clk (clk), .en (adv),
    .n_mag (p4_colmag), .d_mag (p4_tymag), .neg_in (p4_colneg),
    .q (qc), .ovf (ovfc), .neg (negc)
  );

  ssp_div #(.NW(SCLN_W), .DW(32), .QW(BQ_W)) u_div_shift (
    .clk (clk), .en (adv),
    .n_mag (VSH_MAG), .d_mag (p4_tymag), .neg_in (VSH_NEG ^ p4_tyneg),
    .q (qs), .ovf (ovfs), .neg (negs)
  );

  // Height and width use |H / depth| folded with their divisors.
  ssp_div #(.NW(SCLN_W), .DW(BD_W), .QW(BQ_W)) u_div_hgt (
    .clk (clk), .en (adv),
    .n_mag ({cfg.screen_height, 16'd0}), .d_mag (p4_dh), .neg_in (1'b0),
    .q (qh), .ovf (ovfh), .neg (negh_unused)
  );

  ssp_div #(.NW(SCLN_W), .DW(BD_W), .QW(BQ_W)) u_div_wid (
    .clk (clk), .en (adv),
    .n_mag ({cfg.screen_height, 16'd0}), .d_mag (p4_dw), .neg_in (1'b0),
    .q (qw), .ovf (ovfw), .neg (negw_unused)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_col   <= sat_s16(qc, ovfc, negc);
      e1_shift <= sat_s16(qs, ovfs, negs);
      e1_hgt   <= sat_u15(qh, ovfh | negh_unused);
      e1_wid   <= sat_u15(qw, ovfw | negw_unused);
      e1_ty    <= $signed(ty_dly);
    end
  end

  always_comb begin
    hlim   = $signed({5'd0, cfg.screen_height});
    wlim   = $signed({5'd0, cfg.screen_width});
    sy_sum = $signed({6'd0, cfg.screen_height[12:1]}) + 18'(e1_shift)
             - $signed({4'd0, e1_hgt[14:1]});
    ey_sum = $signed({4'd0, e1_hgt[14:1]}) + $signed({6'd0, cfg.screen_height[12:1]})
             + 18'(e1_shift);
    sx_sum = 18'(e1_col) - $signed({4'd0, e1_wid[14:1]});
    ex_sum = $signed({4'd0, e1_wid[14:1]}) + 18'(e1_col);
    ey_lim = (ey_sum >= hlim) ? hlim - 18'sd1 : ey_sum;
    ex_lim = (ex_sum >= wlim) ? wlim - 18'sd1 : ex_sum;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      screen_column    <= e1_col;
      start_x          <= clamp_u15(sx_sum);
      end_x            <= clamp_s16(ex_lim);
      start_y          <= clamp_u15(sy_sum);
      end_y            <= clamp_s16(ey_lim);
      sprite_height_px <= e1_hgt;
      sprite_width_px  <= e1_wid;
      shift_px         <= e1_shift;
      depth            <= e1_ty;
      in_front         <= (e1_ty > 32'sd0);
    end
  end

  assign m_tdata = {3'd0, in_front, depth, shift_px, sprite_width_px, sprite_height_px,
                    end_y, start_y, end_x, start_x, screen_column};

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted transfer did not enter the pipeline");

  a_front_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (in_front == (depth > 32'sd0)))
    else $error("in_front disagrees with depth");

  a_same_div: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (HDIV == WDIV) |-> (sprite_height_px == sprite_width_px))
    else $error("height and width differ with equal divisors");

endmodule
